### hdl/nnm_pkg.sv
package nnm_pkg;

    // saturated L1 distance
    localparam int DIST_W = 20;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register port
    localparam int CFG_W = 32;
    localparam int ADDR_W = 3;
    localparam int DIMENSIONS_W = 5;
    localparam int TRAIN_COUNT_W = 7;
    localparam logic [DIMENSIONS_W-1:0] DIMENSIONS_RST = 5'd16;
    localparam logic [TRAIN_COUNT_W-1:0] TRAIN_COUNT_RST = 7'd64;

    typedef enum logic {
        REG_DIMENSIONS  = 1'b0,
        REG_TRAIN_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESYNC,
        S_SEARCH,
        S_DRAIN,
        S_LABEL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic query_wr;
        logic search_start;
        logic issue;
        logic div_start;
        logic div_step;
        logic div_apply;
        logic label_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic q_last;
        logic issue_last;
        logic pipe_busy;
        logic div_done;
        logic out_free;
        logic load_ok;
    } t_status;

endpackage

### hdl/nnm_ram.sv
module nnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/nnm_regs.sv
module nnm_regs #(
    parameter int DIM_MAX = 16,
    parameter int TRAIN_MAX = 64,
    localparam int DIM_W = $clog2(DIM_MAX + 1),
    localparam int CNT_W = $clog2(TRAIN_MAX + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnm_pkg::ADDR_W-1:0] paddr,
    input  logic [nnm_pkg::CFG_W-1:0]  pwdata,
    output logic [nnm_pkg::CFG_W-1:0]  prdata,
    output logic                       pready,
    output logic                       o_cfg_wr,
    output logic [DIM_W-1:0]           o_eff_dim,
    output logic [CNT_W-1:0]           o_eff_cnt
);

    logic [nnm_pkg::DIMENSIONS_W-1:0]  r_dimensions;
    logic [nnm_pkg::TRAIN_COUNT_W-1:0] r_train_count;
    nnm_pkg::t_reg_idx                 reg_idx;

    assign pready   = 1'b1;
    assign reg_idx  = nnm_pkg::t_reg_idx'(paddr[2]);
    assign o_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimensions  <= nnm_pkg::DIMENSIONS_RST;
            r_train_count <= nnm_pkg::TRAIN_COUNT_RST;
        end else if (o_cfg_wr) begin
            case (reg_idx)
                nnm_pkg::REG_DIMENSIONS: begin
                    r_dimensions <= pwdata[nnm_pkg::DIMENSIONS_W-1:0];
                end
                nnm_pkg::REG_TRAIN_COUNT: begin
                    r_train_count <= pwdata[nnm_pkg::TRAIN_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nnm_pkg::REG_DIMENSIONS:  prdata = nnm_pkg::CFG_W'(r_dimensions);
            nnm_pkg::REG_TRAIN_COUNT: prdata = nnm_pkg::CFG_W'(r_train_count);
            default:                  prdata = '0;
        endcase
    end

    // zero counts as one, anything above the maximum as the maximum
    always_comb begin
        if (r_dimensions == '0) begin
            o_eff_dim = DIM_W'(1);
        end else if (32'(r_dimensions) > DIM_MAX) begin
            o_eff_dim = DIM_W'(DIM_MAX);
        end else begin
            o_eff_dim = DIM_W'(r_dimensions);
        end
    end

    always_comb begin
        if (r_train_count == '0) begin
            o_eff_cnt = CNT_W'(1);
        end else if (32'(r_train_count) > TRAIN_MAX) begin
            o_eff_cnt = CNT_W'(TRAIN_MAX);
        end else begin
            o_eff_cnt = CNT_W'(r_train_count);
        end
    end

endmodule

### hdl/nnm_ctrl.sv
module nnm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_op,
    input  logic              i_cfg_wr,
    input  nnm_pkg::t_status  i_status,
    output nnm_pkg::t_cmd     o_cmd,
    output logic              o_in_stall,
    output nnm_pkg::t_state   o_state
);

    nnm_pkg::t_state r_state;
    nnm_pkg::t_state n_state;
    logic            accept;

    // a register write takes priority over a request in the same cycle
    assign o_in_stall = (r_state != nnm_pkg::S_IDLE) | i_cfg_wr;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_state    = r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nnm_pkg::S_IDLE: begin
                if (i_cfg_wr) begin
                    n_state = nnm_pkg::S_RESYNC;
                end else if (accept && i_op == nnm_pkg::OP_QUERY && i_status.q_last) begin
                    n_state = nnm_pkg::S_SEARCH;
                end
            end
            nnm_pkg::S_RESYNC: begin
                if (!i_cfg_wr && i_status.div_done) begin
                    n_state = nnm_pkg::S_IDLE;
                end
            end
            nnm_pkg::S_SEARCH: begin
                if (i_status.issue_last) begin
                    n_state = nnm_pkg::S_DRAIN;
                end
            end
            nnm_pkg::S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = nnm_pkg::S_LABEL;
                end
            end
            nnm_pkg::S_LABEL: begin
                n_state = nnm_pkg::S_OUT;
            end
            nnm_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = nnm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nnm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            nnm_pkg::S_IDLE: begin
                o_cmd.load_wr      = accept & (i_op == nnm_pkg::OP_LOAD);
                o_cmd.query_wr     = accept & (i_op == nnm_pkg::OP_QUERY);
                o_cmd.search_start = accept & (i_op == nnm_pkg::OP_QUERY) & i_status.q_last;
                o_cmd.div_start    = i_cfg_wr;
            end
            nnm_pkg::S_RESYNC: begin
                o_cmd.div_start = i_cfg_wr;
                o_cmd.div_step  = ~i_cfg_wr & ~i_status.div_done;
                o_cmd.div_apply = ~i_cfg_wr & i_status.div_done;
            end
            nnm_pkg::S_SEARCH: begin
                o_cmd.issue = 1'b1;
            end
            nnm_pkg::S_LABEL: begin
                o_cmd.label_rd = 1'b1;
            end
            nnm_pkg::S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

### hdl/nnm_dp.sv
module nnm_dp #(
    parameter int DIM_MAX = 16,
    parameter int TRAIN_MAX = 64,
    parameter int ELEM_W = 16,
    parameter int LABEL_W = 8,
    localparam int DIM_W = $clog2(DIM_MAX + 1),
    localparam int CNT_W = $clog2(TRAIN_MAX + 1),
    localparam int T_W = (TRAIN_MAX > 1) ? $clog2(TRAIN_MAX) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nnm_pkg::t_cmd              i_cmd,
    output nnm_pkg::t_status           o_status,
    input  logic [DIM_W-1:0]           i_eff_dim,
    input  logic [CNT_W-1:0]           i_eff_cnt,
    input  logic [ELEM_W-1:0]          i_value,
    input  logic [LABEL_W-1:0]         i_label,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [LABEL_W-1:0]         o_class_label,
    output logic [T_W-1:0]             o_nearest_index,
    output logic [nnm_pkg::DIST_W-1:0] o_nearest_dist
);

    localparam int D_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int TA_DEPTH = TRAIN_MAX * DIM_MAX;
    localparam int TA_W = (TA_DEPTH > 1) ? $clog2(TA_DEPTH) : 1;
    localparam int TOT_W = DIM_W + CNT_W;
    localparam int DC_W = $clog2(TA_W + 1);
    localparam int SUM_W = ((nnm_pkg::DIST_W > ELEM_W + 1) ? nnm_pkg::DIST_W : ELEM_W + 1) + 1;

    // load pointer, kept both linear and as vector / element
    logic [TA_W-1:0]  r_lp;
    logic [T_W-1:0]   r_ld_t;
    logic [D_W-1:0]   r_ld_d;
    logic [D_W-1:0]   r_qp;
    logic [TOT_W-1:0] total;
    logic [TA_W-1:0]  lp_cur;
    logic [TA_W-1:0]  ld_addr;
    logic             ld_last;
    logic             ld_d_last;

    // restoring divider that maps the linear pointer to vector / element
    logic [TA_W-1:0]  r_dq;
    logic [DIM_W-1:0] r_rem;
    logic [DC_W-1:0]  r_dcnt;
    logic [DIM_W:0]   rem_sh;
    logic             rem_ge;

    // search sweep
    logic [T_W-1:0]   r_st;
    logic [D_W-1:0]   r_sd;
    logic [TA_W-1:0]  rd_addr;
    logic             s_d_last;
    logic             s_t_last;

    logic             r_p1_valid;
    logic             r_p1_first;
    logic             r_p1_last;
    logic [T_W-1:0]   r_p1_t;
    logic             r_p2_valid;
    logic             r_p2_first;
    logic             r_p2_last;
    logic [T_W-1:0]   r_p2_t;
    logic [ELEM_W:0]  r_abs;
    logic             r_p3_valid;
    logic             r_p3_last;
    logic [T_W-1:0]   r_p3_t;
    logic [nnm_pkg::DIST_W-1:0] r_acc;
    logic [nnm_pkg::DIST_W-1:0] r_best;
    logic [T_W-1:0]   r_best_t;

    logic [ELEM_W-1:0]       q_rd;
    logic [ELEM_W-1:0]       tr_rd;
    logic [LABEL_W-1:0]      lab_rd;
    logic signed [ELEM_W:0]  diff;
    logic [ELEM_W:0]         mag;
    logic [nnm_pkg::DIST_W-1:0] acc_base;
    logic [SUM_W-1:0]        sum;
    logic [nnm_pkg::DIST_W-1:0] n_acc;

    logic                       r_out_valid;
    logic [LABEL_W-1:0]         r_out_label;
    logic [T_W-1:0]             r_out_idx;
    logic [nnm_pkg::DIST_W-1:0] r_out_dist;

    assign total     = TOT_W'(i_eff_dim) * TOT_W'(i_eff_cnt);
    // a pointer left beyond a shrunk set restarts at zero on the next load
    assign lp_cur    = o_status.load_ok ? r_lp : '0;
    assign ld_addr   = TA_W'(32'(r_ld_t) * DIM_MAX + 32'(r_ld_d));
    assign ld_last   = (32'(lp_cur) + 32'd1) >= 32'(total);
    assign ld_d_last = (32'(r_ld_d) + 32'd1) == 32'(i_eff_dim);

    assign rem_sh = {r_rem, r_dq[TA_W-1]};
    assign rem_ge = rem_sh >= (DIM_W + 1)'(i_eff_dim);

    assign rd_addr  = TA_W'(32'(r_st) * DIM_MAX + 32'(r_sd));
    assign s_d_last = (32'(r_sd) + 32'd1) == 32'(i_eff_dim);
    assign s_t_last = (32'(r_st) + 32'd1) == 32'(i_eff_cnt);

    // a query may also finish early when the dimension count has shrunk
    assign o_status.q_last     = (32'(r_qp) + 32'd1) >= 32'(i_eff_dim);
    assign o_status.issue_last = i_cmd.issue & s_d_last & s_t_last;
    assign o_status.pipe_busy  = r_p1_valid | r_p2_valid | r_p3_valid;
    assign o_status.div_done   = 32'(r_dcnt) == TA_W;
    assign o_status.out_free   = ~r_out_valid | ~i_out_stall;
    assign o_status.load_ok    = 32'(r_lp) < 32'(total);

    nnm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (TA_DEPTH)
    ) u_train_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (ld_addr),
        .i_wdata (i_value),
        .i_re    (i_cmd.issue),
        .i_raddr (rd_addr),
        .o_rdata (tr_rd)
    );

    nnm_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (TRAIN_MAX)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr & (r_ld_d == '0)),
        .i_waddr (r_ld_t),
        .i_wdata (i_label),
        .i_re    (i_cmd.label_rd),
        .i_raddr (r_best_t),
        .o_rdata (lab_rd)
    );

    nnm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DIM_MAX)
    ) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.query_wr),
        .i_waddr (r_qp),
        .i_wdata (i_value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_sd),
        .o_rdata (q_rd)
    );

    // load and query pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_ld_t <= '0;
            r_ld_d <= '0;
            r_qp   <= '0;
        end else begin
            if (i_cmd.load_wr) begin
                if (ld_last) begin
                    r_lp   <= '0;
                    r_ld_t <= '0;
                    r_ld_d <= '0;
                end else begin
                    r_lp <= lp_cur + TA_W'(1);
                    if (ld_d_last) begin
                        r_ld_d <= '0;
                        r_ld_t <= r_ld_t + T_W'(1);
                    end else begin
                        r_ld_d <= r_ld_d + D_W'(1);
                    end
                end
            end else if (i_cmd.div_apply) begin
                if (!o_status.load_ok) begin
                    r_ld_t <= '0;
                    r_ld_d <= '0;
                end else begin
                    r_ld_t <= r_dq[T_W-1:0];
                    r_ld_d <= r_rem[D_W-1:0];
                end
            end
            if (i_cmd.query_wr) begin
                r_qp <= o_status.q_last ? '0 : r_qp + D_W'(1);
            end
        end
    end

    // one quotient bit per cycle; a register write restarts the division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq  <= r_lp;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= TA_W'({r_dq, rem_ge});
            r_rem <= rem_ge ? DIM_W'(rem_sh - (DIM_W + 1)'(i_eff_dim)) : DIM_W'(rem_sh);
        end
    end

    // sweep over every element of every stored vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_sd <= '0;
        end else if (i_cmd.search_start) begin
            r_st <= '0;
            r_sd <= '0;
        end else if (i_cmd.issue) begin
            if (s_d_last) begin
                r_sd <= '0;
                r_st <= r_st + T_W'(1);
            end else begin
                r_sd <= r_sd + D_W'(1);
            end
        end
    end

    always_comb begin
        diff     = $signed({q_rd[ELEM_W-1], q_rd}) - $signed({tr_rd[ELEM_W-1], tr_rd});
        mag      = diff[ELEM_W] ? (ELEM_W + 1)'(-diff) : (ELEM_W + 1)'(diff);
        acc_base = r_p2_first ? '0 : r_acc;
        sum      = SUM_W'(acc_base) + SUM_W'(r_abs);
        n_acc    = (sum > SUM_W'(nnm_pkg::DIST_MAX)) ? nnm_pkg::DIST_MAX
                                                     : nnm_pkg::DIST_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= r_sd == '0;
        r_p1_last  <= s_d_last;
        r_p1_t     <= r_st;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_t     <= r_p1_t;
        r_abs      <= mag;
        r_p3_last  <= r_p2_last;
        r_p3_t     <= r_p2_t;
        if (r_p2_valid) begin
            r_acc <= n_acc;
        end
        // the first vector is always taken, later ones only when strictly closer
        if (r_p3_valid && r_p3_last && (r_p3_t == '0 || r_acc < r_best)) begin
            r_best   <= r_acc;
            r_best_t <= r_p3_t;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_label <= lab_rd;
            r_out_idx   <= r_best_t;
            r_out_dist  <= r_best;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_class_label   = r_out_label;
    assign o_nearest_index = r_out_idx;
    assign o_nearest_dist  = r_out_dist;

endmodule

### hdl/nearest_neighbor_manhattan.sv
// channel   direction  handshake                 payload
// in        request    i_in_valid / o_in_stall   i_op, i_value, i_label
// out       result     o_out_valid / i_out_stall o_class_label, o_nearest_index, o_nearest_dist
// config    APB        psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// a training element or a query element that does not close its query leaves the controller idle
// the closing query element runs the search, drain, label and output states: the sweep
// reads one stored element a cycle from the single read port of the training memory
// each register write is followed by a pointer remap with requests stalled;
// reset restores the registers and pointers, not the stores
// a waiting result only holds up the next closing query, not loads or other elements
module nearest_neighbor_manhattan #(
    parameter int DIM_MAX = 16,
    parameter int TRAIN_MAX = 64,
    parameter int ELEM_W = 16,
    parameter int LABEL_W = 8,
    localparam int T_W = (TRAIN_MAX > 1) ? $clog2(TRAIN_MAX) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnm_pkg::ADDR_W-1:0] paddr,
    input  logic [nnm_pkg::CFG_W-1:0]  pwdata,
    output logic [nnm_pkg::CFG_W-1:0]  prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic [ELEM_W-1:0]          i_value,
    input  logic [LABEL_W-1:0]         i_label,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [LABEL_W-1:0]         o_class_label,
    output logic [T_W-1:0]             o_nearest_index,
    output logic [nnm_pkg::DIST_W-1:0] o_nearest_dist
);

    localparam int DIM_W = $clog2(DIM_MAX + 1);
    localparam int CNT_W = $clog2(TRAIN_MAX + 1);

    logic             cfg_wr;
    logic [DIM_W-1:0] eff_dim;
    logic [CNT_W-1:0] eff_cnt;
    nnm_pkg::t_cmd    dp_cmd;
    nnm_pkg::t_status dp_status;
    nnm_pkg::t_state  ctrl_state;

    nnm_regs #(
        .DIM_MAX   (DIM_MAX),
        .TRAIN_MAX (TRAIN_MAX)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg_wr  (cfg_wr),
        .o_eff_dim (eff_dim),
        .o_eff_cnt (eff_cnt)
    );

    nnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_cfg_wr   (cfg_wr),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall),
        .o_state    (ctrl_state)
    );

    nnm_dp #(
        .DIM_MAX   (DIM_MAX),
        .TRAIN_MAX (TRAIN_MAX),
        .ELEM_W    (ELEM_W),
        .LABEL_W   (LABEL_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_eff_dim       (eff_dim),
        .i_eff_cnt       (eff_cnt),
        .i_value         (i_value),
        .i_label         (i_label),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_class_label   (o_class_label),
        .o_nearest_index (o_nearest_index),
        .o_nearest_dist  (o_nearest_dist)
    );

    a_result_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl_state == nnm_pkg::S_OUT))
        else $error("result raised outside the output state");

    a_stall_unless_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_state != nnm_pkg::S_IDLE) |-> o_in_stall)
        else $error("request taken while the controller is busy");

    a_pipe_only_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.pipe_busy |->
            (ctrl_state == nnm_pkg::S_SEARCH || ctrl_state == nnm_pkg::S_DRAIN))
        else $error("distance pipeline active outside the sweep");

endmodule
